FILE: src/mqd_pkg.sv
// Shared request/response types and code constants for the multi-queue deque.
`default_nettype none
package mqd_pkg;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_TAKE   = 1'b1;

  // Result codes.
  localparam logic [1:0] RC_OK        = 2'd0;
  localparam logic [1:0] RC_FULL      = 2'd1;
  localparam logic [1:0] RC_EMPTY     = 2'd2;
  localparam logic [1:0] RC_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  queue_index;
    logic [15:0] entry_tag;
    logic        urgent;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [15:0] taken_tag;
    logic        taken_urgent;
    logic [3:0]  length_after;
  } rsp_t;

endpackage
`default_nettype wire

FILE: src/multi_queue_two_priority_deque_top.sv
// Top level of the multi-queue deque: request sequencer around the state and entry RAMs.
// Sequence: an accepted request is looked up in the state RAM, a successful take then
// reads the entry RAM, and the finish step registers the result beat; a bad queue index
// goes straight from acceptance to the finish step. One request is handled at a time: a
// new one is taken only once the last result has moved into the output register.
// Reset: synchronous; all queues read as empty at once, entry contents stay undefined.
`default_nettype none
module multi_queue_two_priority_deque_top
  import mqd_pkg::*;
#(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 8,
  parameter int TAG_WIDTH   = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  // Queue select, head pointer and length widths.
  localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HW   = $clog2(QUEUE_DEPTH);
  localparam int LW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW = LW + 1;
  localparam int AW   = QW + HW;
  localparam int DW   = TAG_WIDTH + 1;

  localparam logic [LW-1:0]   DEPTH_L   = LW'(QUEUE_DEPTH);
  localparam logic [SUMW-1:0] DEPTH_S   = SUMW'(QUEUE_DEPTH);
  localparam logic [HW-1:0]   LAST_SLOT = HW'(QUEUE_DEPTH - 1);
  localparam logic [5:0]      NQ_L      = 6'(NUM_QUEUES);

  // The sequencer walks each request through lookup, an optional entry read for a take,
  // and a final step that hands the result to the output register.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_READ,
    S_FINISH
  } state_t;

  state_t        state;
  req_t          req_q;
  rsp_t          res;

  logic [HW-1:0] cur_head;
  logic [LW-1:0] cur_len;
  logic [QW-1:0] cur_q;
  logic          accept;
  logic          bad_index;
  logic          load_rsp;

  logic          st_rd_en;
  logic          st_wr_en;
  logic [HW-1:0] st_wr_head;
  logic [LW-1:0] st_wr_len;

  logic          ent_wr_en;
  logic          ent_rd_en;
  logic [HW-1:0] slot;
  logic [AW-1:0] ent_addr;
  logic [DW-1:0] ent_rd_data;

  logic [SUMW-1:0] tail_sum;
  logic [HW-1:0]   tail_slot;
  logic [HW-1:0]   head_dec;
  logic [HW-1:0]   head_inc;
  logic            is_full;
  logic            is_empty;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign bad_index = {1'b0, req.queue_index} >= NQ_L;
  assign st_rd_en  = accept;
  assign cur_q     = req_q.queue_index[QW-1:0];

  // The finished result moves to the output register once the previous beat has left it.
  assign load_rsp  = (state == S_FINISH) && (!rsp_valid || rsp_ready);

  mqd_state_mem #(
    .NUM_QUEUES(NUM_QUEUES),
    .QW        (QW),
    .HW        (HW),
    .LW        (LW)
  ) u_state (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (st_rd_en),
    .rd_addr(req.queue_index[QW-1:0]),
    .rd_head(cur_head),
    .rd_len (cur_len),
    .wr_en  (st_wr_en),
    .wr_addr(cur_q),
    .wr_head(st_wr_head),
    .wr_len (st_wr_len)
  );

  // Ring arithmetic. The head stays below the depth and the length is below the depth
  // whenever a tail slot is used, so one conditional subtract wraps the sum.
  assign tail_sum  = SUMW'(cur_head) + SUMW'(cur_len);
  assign tail_slot = (tail_sum >= DEPTH_S) ? HW'(tail_sum - DEPTH_S) : HW'(tail_sum);
  assign head_dec  = (cur_head == '0) ? LAST_SLOT : cur_head - HW'(1);
  assign head_inc  = (cur_head == LAST_SLOT) ? '0 : cur_head + HW'(1);
  assign is_full   = (cur_len == DEPTH_L);
  assign is_empty  = (cur_len == '0);

  always_comb begin
    st_wr_en   = 1'b0;
    st_wr_head = cur_head;
    st_wr_len  = cur_len;
    ent_wr_en  = 1'b0;
    ent_rd_en  = 1'b0;
    slot       = cur_head;
    if (state == S_LOOKUP) begin
      if (req_q.req_type == REQ_INSERT) begin
        if (!is_full) begin
          st_wr_en  = 1'b1;
          ent_wr_en = 1'b1;
          st_wr_len = cur_len + LW'(1);
          if (req_q.urgent) begin
            // An urgent entry goes in front of the current head.
            st_wr_head = head_dec;
            slot       = head_dec;
          end else begin
            slot = tail_slot;
          end
        end
      end else if (!is_empty) begin
        st_wr_en   = 1'b1;
        ent_rd_en  = 1'b1;
        st_wr_head = head_inc;
        st_wr_len  = cur_len - LW'(1);
      end
    end
  end

  assign ent_addr = {cur_q, slot};

  mqd_entry_mem #(
    .AW(AW),
    .DW(DW)
  ) u_entry (
    .clk    (clk),
    .wr_en  (ent_wr_en),
    .wr_addr(ent_addr),
    .wr_data({req_q.urgent, req_q.entry_tag[TAG_WIDTH-1:0]}),
    .rd_en  (ent_rd_en),
    .rd_addr(ent_addr),
    .rd_data(ent_rd_data)
  );

  // Sequencer state, the pending result and the output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_q                <= req;
            res.taken_tag        <= '0;
            res.taken_urgent     <= 1'b0;
            res.length_after     <= '0;
            if (bad_index) begin
              res.result_code <= RC_BAD_INDEX;
              state           <= S_FINISH;
            end else begin
              res.result_code <= RC_OK;
              state           <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          res.length_after <= 4'(st_wr_len);
          state            <= S_FINISH;
          if (req_q.req_type == REQ_INSERT) begin
            if (is_full) begin
              res.result_code <= RC_FULL;
            end
          end else if (is_empty) begin
            res.result_code <= RC_EMPTY;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          res.taken_tag    <= 16'(ent_rd_data[TAG_WIDTH-1:0]);
          res.taken_urgent <= ent_rd_data[TAG_WIDTH];
          state            <= S_FINISH;
        end
        S_FINISH: begin
          // Wait here while the previous beat still sits in the output register.
          if (load_rsp) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/mqd_entry_mem.sv
// Entry storage: one synchronous RAM holding tag and urgent flag per queue slot.
`default_nettype none
module mqd_entry_mem #(
  parameter int AW = 7,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: src/mqd_state_mem.sv
// Per-queue head pointer and length RAM, with per-queue valid bits so reset reads as empty.
`default_nettype none
module mqd_state_mem #(
  parameter int NUM_QUEUES = 16,
  parameter int QW = 4,
  parameter int HW = 3,
  parameter int LW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [QW-1:0] rd_addr,
  output logic      [HW-1:0] rd_head,
  output logic      [LW-1:0] rd_len,
  input  wire logic          wr_en,
  input  wire logic [QW-1:0] wr_addr,
  input  wire logic [HW-1:0] wr_head,
  input  wire logic [LW-1:0] wr_len
);

  logic [HW+LW-1:0]     mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] vld;
  logic [HW+LW-1:0]     rd_word;
  logic                 rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_head, wr_len};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // A queue never written since reset is empty with its head at slot zero.
  assign rd_head = rd_vld ? rd_word[HW+LW-1:LW] : '0;
  assign rd_len  = rd_vld ? rd_word[LW-1:0]     : '0;

endmodule
`default_nettype wire
